// File: hdl/mqd_pkg.sv
// Shared types and constants for the Mahalanobis quadratic distance block.
// No dependencies; imported by every module under hdl/ except mqd_ram.
package mqd_pkg;

    localparam int VAL_W   = 16;
    localparam int DIFF_W  = 17;
    localparam int PROD1_W = 34;
    localparam int TERM_W  = 52;
    localparam int DIST_W  = 56;
    localparam int MUL_A_W = 35;
    localparam int MUL_B_W = 18;

    // item op codes
    localparam logic [1:0] OP_WEIGHT  = 2'd0;
    localparam logic [1:0] OP_CENTER  = 2'd1;
    localparam logic [1:0] OP_FEATURE = 2'd2;

    // configuration register indexes
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_FEATURES = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_CLUSTERS = 1'b1;

    typedef struct packed {
        logic [1:0]               op;
        logic [1:0]               cluster_sel;
        logic [2:0]               row_index;
        logic [2:0]               col_index;
        logic signed [VAL_W-1:0]  value;
        logic                     last_element;
    } t_in_item;

    typedef struct packed {
        logic [1:0]               cluster_id;
        logic signed [DIST_W-1:0] distance;
        logic                     last_result;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CEN,
        S_DIFF,
        S_RW1,
        S_RW2,
        S_MUL1,
        S_MUL2,
        S_ACC,
        S_EMIT,
        S_CLEAR
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic wr_weight;
        logic wr_center;
        logic take_x;
        logic diff_wr;
        logic cap_w;
        logic w_swap;
        logic mul_dd;
        logic mul_dw;
        logic diag;
        logic acc;
        logic emit;
        logic last_res;
        logic clear;
    } t_dp_cmd;

endpackage

// File: hdl/mqd_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module mqd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/mqd_datapath.sv
// Datapath: weight, centre and difference stores, one shared multiplier,
// per-cluster accumulators and the result register. Depends on mqd_pkg, mqd_ram.
module mqd_datapath
    import mqd_pkg::*;
#(
    parameter int MAX_FEATURES = 8,
    parameter int MAX_CLUSTERS = 4
) (
    input  logic                                                 i_clk,
    input  logic                                                 i_rst_n,
    input  t_dp_cmd                                              i_cmd,
    input  logic [(MAX_CLUSTERS > 1 ? $clog2(MAX_CLUSTERS) : 1)-1:0] i_c,
    input  logic [(MAX_FEATURES > 1 ? $clog2(MAX_FEATURES) : 1)-1:0] i_i,
    input  logic [(MAX_FEATURES > 1 ? $clog2(MAX_FEATURES) : 1)-1:0] i_j,
    input  t_in_item                                             i_item,
    output t_out_item                                            o_res,
    output logic                                                 o_res_strobe
);

    localparam int W_DEPTH = MAX_CLUSTERS * MAX_FEATURES * MAX_FEATURES;
    localparam int C_DEPTH = MAX_CLUSTERS * MAX_FEATURES;
    localparam int WAW    = W_DEPTH > 1 ? $clog2(W_DEPTH) : 1;
    localparam int CAW    = C_DEPTH > 1 ? $clog2(C_DEPTH) : 1;

    logic [WAW-1:0] w_waddr, w_raddr;
    logic [CAW-1:0] c_waddr, cd_raddr, d_waddr;
    logic [VAL_W-1:0] w_rdata, c_rdata;
    logic [DIFF_W-1:0] d_rdata;
    logic signed [DIFF_W-1:0] diff;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_A_W+MUL_B_W-1:0] mul_p;

    logic signed [VAL_W-1:0]   r_x;
    logic signed [DIFF_W-1:0]  r_d;
    logic signed [DIFF_W-1:0]  r_dj;
    logic signed [VAL_W-1:0]   r_w;
    logic signed [DIFF_W-1:0]  r_wsum;
    logic signed [PROD1_W-1:0] r_p;
    logic signed [TERM_W-1:0]  r_term;
    logic signed [DIST_W-1:0]  r_acc [MAX_CLUSTERS];
    t_out_item                 r_res;
    logic                      r_res_strobe;

    // load addresses straight from the item fields; range checked upstream
    assign w_waddr = WAW'((int'(i_item.cluster_sel) * MAX_FEATURES + int'(i_item.row_index))
                          * MAX_FEATURES + int'(i_item.col_index));
    assign c_waddr = CAW'(int'(i_item.cluster_sel) * MAX_FEATURES + int'(i_item.row_index));

    // second weight read fetches the transposed entry
    assign w_raddr = i_cmd.w_swap
        ? WAW'((int'(i_c) * MAX_FEATURES + int'(i_j)) * MAX_FEATURES + int'(i_i))
        : WAW'((int'(i_c) * MAX_FEATURES + int'(i_i)) * MAX_FEATURES + int'(i_j));
    assign cd_raddr = CAW'(int'(i_c) * MAX_FEATURES + int'(i_j));
    assign d_waddr  = CAW'(int'(i_c) * MAX_FEATURES + int'(i_i));

    logic [CAW-1:0] cen_raddr;
    assign cen_raddr = d_waddr;

    mqd_ram #(.WIDTH(VAL_W), .DEPTH(W_DEPTH)) u_weight_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_weight),
        .i_waddr (w_waddr),
        .i_wdata (i_item.value),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    mqd_ram #(.WIDTH(VAL_W), .DEPTH(C_DEPTH)) u_center_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_center),
        .i_waddr (c_waddr),
        .i_wdata (i_item.value),
        .i_raddr (cen_raddr),
        .o_rdata (c_rdata)
    );

    mqd_ram #(.WIDTH(DIFF_W), .DEPTH(C_DEPTH)) u_diff_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.diff_wr),
        .i_waddr (d_waddr),
        .i_wdata (diff),
        .i_raddr (cd_raddr),
        .o_rdata (d_rdata)
    );

    assign diff = {r_x[VAL_W-1], r_x} - {c_rdata[VAL_W-1], c_rdata};

    // shared multiplier: d*dj first, then that product times the weight sum
    always_comb begin
        if (i_cmd.mul_dw) begin
            mul_a = {r_p[PROD1_W-1], r_p};
            mul_b = r_wsum[DIFF_W-1] ? {1'b1, r_wsum} : {1'b0, r_wsum};
        end else begin
            mul_a = {{(MUL_A_W-DIFF_W){r_d[DIFF_W-1]}}, r_d};
            mul_b = i_cmd.diag ? {r_d[DIFF_W-1], r_d} : {r_dj[DIFF_W-1], r_dj};
        end
    end

    assign mul_p = mul_a * mul_b;

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_x) begin
            r_x <= i_item.value;
        end
        if (i_cmd.diff_wr) begin
            r_d <= diff;
        end
        if (i_cmd.cap_w) begin
            r_w  <= w_rdata;
            r_dj <= d_rdata;
        end
        if (i_cmd.mul_dd) begin
            r_p    <= PROD1_W'(mul_p);
            r_wsum <= i_cmd.diag ? {r_w[VAL_W-1], r_w}
                                 : {r_w[VAL_W-1], r_w} + {w_rdata[VAL_W-1], w_rdata};
        end
        if (i_cmd.mul_dw) begin
            r_term <= TERM_W'(mul_p);
        end
        r_res.cluster_id  <= 2'(i_c);
        r_res.distance    <= r_acc[i_c];
        r_res.last_result <= i_cmd.last_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_CLUSTERS; k++) begin
                r_acc[k] <= '0;
            end
            r_res_strobe <= 1'b0;
        end else begin
            r_res_strobe <= i_cmd.emit;
            if (i_cmd.clear) begin
                for (int k = 0; k < MAX_CLUSTERS; k++) begin
                    r_acc[k] <= '0;
                end
            end else if (i_cmd.acc) begin
                r_acc[i_c] <= r_acc[i_c] + {{(DIST_W-TERM_W){r_term[TERM_W-1]}}, r_term};
            end
        end
    end

    assign o_res        = r_res;
    assign o_res_strobe = r_res_strobe;

endmodule

// File: hdl/mqd_ctrl.sv
// Controller: configuration registers, element counter and the sequencer
// that walks clusters and terms. Depends on mqd_pkg.
module mqd_ctrl
    import mqd_pkg::*;
#(
    parameter int MAX_FEATURES = 8,
    parameter int MAX_CLUSTERS = 4
) (
    input  logic                                                 i_clk,
    input  logic                                                 i_rst_n,
    input  logic                                                 start,
    output logic                                                 busy,
    input  t_in_item                                             i_item,
    input  logic                                                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0]                                 i_cfg_index,
    input  logic [CFG_DATA_W-1:0]                                i_cfg_data,
    output t_dp_cmd                                              o_cmd,
    output logic [(MAX_CLUSTERS > 1 ? $clog2(MAX_CLUSTERS) : 1)-1:0] o_c,
    output logic [(MAX_FEATURES > 1 ? $clog2(MAX_FEATURES) : 1)-1:0] o_i,
    output logic [(MAX_FEATURES > 1 ? $clog2(MAX_FEATURES) : 1)-1:0] o_j
);

    localparam int FIW = MAX_FEATURES > 1 ? $clog2(MAX_FEATURES) : 1;
    localparam int CIW = MAX_CLUSTERS > 1 ? $clog2(MAX_CLUSTERS) : 1;
    localparam int ECW = $clog2(MAX_FEATURES + 1);

    t_state           r_state, n_state;
    logic [3:0]       r_feat;
    logic [2:0]       r_clus;
    logic [ECW-1:0]   r_elem, n_elem;
    logic             r_last, n_last;
    logic [CIW-1:0]   r_c, n_c;
    logic [FIW-1:0]   r_i, n_i;
    logic [FIW-1:0]   r_j, n_j;

    logic accept;
    logic feat_ok;
    logic load_ok;
    logic last_clus;
    int   eff_clus;

    assign accept   = start && (r_state == S_IDLE);
    assign feat_ok  = (int'(r_elem) < int'(r_feat)) && (int'(r_elem) < MAX_FEATURES);
    assign load_ok  = (int'(i_item.cluster_sel) < MAX_CLUSTERS)
                   && (int'(i_item.row_index) < MAX_FEATURES);
    assign eff_clus = (int'(r_clus) < MAX_CLUSTERS) ? int'(r_clus) : MAX_CLUSTERS;
    assign last_clus = (int'(r_c) + 1 == eff_clus);

    // next state and counters
    always_comb begin
        n_state = r_state;
        n_elem  = r_elem;
        n_last  = r_last;
        n_c     = r_c;
        n_i     = r_i;
        n_j     = r_j;
        unique case (r_state)
            S_IDLE: begin
                if (accept && i_item.op == OP_FEATURE) begin
                    n_last = i_item.last_element;
                    n_c    = '0;
                    if (int'(r_elem) < MAX_FEATURES) begin
                        n_elem = r_elem + ECW'(1);
                    end
                    if (feat_ok) begin
                        n_i     = FIW'(r_elem);
                        n_state = S_CEN;
                    end else if (i_item.last_element) begin
                        n_state = (eff_clus > 0) ? S_EMIT : S_CLEAR;
                    end
                end
            end
            S_CEN:  n_state = S_DIFF;
            S_DIFF: begin
                n_j     = '0;
                n_state = S_RW1;
            end
            S_RW1:  n_state = S_RW2;
            S_RW2:  n_state = S_MUL1;
            S_MUL1: n_state = S_MUL2;
            S_MUL2: n_state = S_ACC;
            S_ACC: begin
                if (r_j != r_i) begin
                    n_j     = r_j + FIW'(1);
                    n_state = S_RW1;
                end else if (int'(r_c) != MAX_CLUSTERS - 1) begin
                    n_c     = r_c + CIW'(1);
                    n_state = S_CEN;
                end else if (r_last) begin
                    n_c     = '0;
                    n_state = (eff_clus > 0) ? S_EMIT : S_CLEAR;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_EMIT: begin
                if (last_clus) begin
                    n_state = S_CLEAR;
                end else begin
                    n_c = r_c + CIW'(1);
                end
            end
            S_CLEAR: begin
                n_elem  = '0;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // command decode
    always_comb begin
        o_cmd = '0;
        busy  = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                o_cmd.wr_weight = accept && (i_item.op == OP_WEIGHT) && load_ok
                               && (int'(i_item.col_index) < MAX_FEATURES);
                o_cmd.wr_center = accept && (i_item.op == OP_CENTER) && load_ok;
                o_cmd.take_x    = accept && (i_item.op == OP_FEATURE);
            end
            S_CEN:  ;
            S_DIFF: o_cmd.diff_wr = 1'b1;
            S_RW1:  ;
            S_RW2: begin
                o_cmd.cap_w  = 1'b1;
                o_cmd.w_swap = 1'b1;
            end
            S_MUL1: begin
                o_cmd.mul_dd = 1'b1;
                o_cmd.diag   = (r_j == r_i);
            end
            S_MUL2: o_cmd.mul_dw = 1'b1;
            S_ACC:  o_cmd.acc = 1'b1;
            S_EMIT: begin
                o_cmd.emit     = 1'b1;
                o_cmd.last_res = last_clus;
            end
            S_CLEAR: o_cmd.clear = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_feat  <= 4'd8;
            r_clus  <= 3'd4;
            r_elem  <= '0;
            r_last  <= 1'b0;
            r_c     <= '0;
            r_i     <= '0;
            r_j     <= '0;
        end else begin
            r_state <= n_state;
            r_elem  <= n_elem;
            r_last  <= n_last;
            r_c     <= n_c;
            r_i     <= n_i;
            r_j     <= n_j;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_ACTIVE_FEATURES: r_feat <= i_cfg_data;
                    CFG_ACTIVE_CLUSTERS: r_clus <= i_cfg_data[2:0];
                    default: ;
                endcase
            end
        end
    end

    assign o_c = r_c;
    assign o_i = r_i;
    assign o_j = r_j;

endmodule

// File: hdl/mahalanobis_quadratic_distance_top.sv
// Top level of the Mahalanobis quadratic distance block.
// Depends on mqd_pkg, mqd_ctrl, mqd_datapath (and mqd_ram below it).
//
//  channel  | handshake          | payload
//  ---------+--------------------+-----------------------------------------
//  item in  | start, busy        | i_item  (t_in_item)
//  result   | o_res_strobe       | o_res   (t_out_item), one cycle per beat
//  config   | i_cfg_we           | i_cfg_index, i_cfg_data
//
// Load beats are written in the cycle they are taken; busy stays low.
// A feature element at position i runs all MAX_CLUSTERS clusters over i+1 terms each:
// one shared multiplier, two passes per term, single-port weight reads.
// Closing a pattern emits one result per active cluster, then clears the accumulators.
// Reset is synchronous; no clearing pass, the stores are undefined until written.
// Results cannot be held off: each beat is valid for exactly one cycle.
module mahalanobis_quadratic_distance_top
    import mqd_pkg::*;
#(
    parameter int MAX_FEATURES = 8,
    parameter int MAX_CLUSTERS = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  t_in_item              i_item,
    output t_out_item             o_res,
    output logic                  o_res_strobe,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int FIW = MAX_FEATURES > 1 ? $clog2(MAX_FEATURES) : 1;
    localparam int CIW = MAX_CLUSTERS > 1 ? $clog2(MAX_CLUSTERS) : 1;

    t_dp_cmd        cmd;
    logic [CIW-1:0] idx_c;
    logic [FIW-1:0] idx_i;
    logic [FIW-1:0] idx_j;

    mqd_ctrl #(
        .MAX_FEATURES (MAX_FEATURES),
        .MAX_CLUSTERS (MAX_CLUSTERS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cmd       (cmd),
        .o_c         (idx_c),
        .o_i         (idx_i),
        .o_j         (idx_j)
    );

    mqd_datapath #(
        .MAX_FEATURES (MAX_FEATURES),
        .MAX_CLUSTERS (MAX_CLUSTERS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_c          (idx_c),
        .i_i          (idx_i),
        .i_j          (idx_j),
        .i_item       (i_item),
        .o_res        (o_res),
        .o_res_strobe (o_res_strobe)
    );

endmodule
